### src/bbd_pkg.sv
// Shared types, constants and averaging helpers for the Bayer demosaic block.
package bbd_pkg;

    localparam int MAX_WIDTH_DEF = 4096;
    localparam int PIX_W         = 8;
    localparam int POS_W         = 12;
    localparam int CFG_W         = 13;
    localparam int LS_W          = 3 * PIX_W;
    localparam int COL_W         = 4 * PIX_W;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef logic [PIX_W-1:0] pix_t;

    // One 2x2 quad of BGR pixels; entry k is pixel (row + k[1], col + k[0]).
    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        pix_t [3:0]       blue;
        pix_t [3:0]       green;
        pix_t [3:0]       red;
    } quad_t;

    // Truncating mean of two samples.
    function automatic pix_t avg2(input pix_t a, input pix_t b);
        logic [PIX_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[PIX_W:1];
    endfunction

    // Truncating mean of four samples.
    function automatic pix_t avg4(input pix_t a, input pix_t b, input pix_t c, input pix_t d);
        logic [PIX_W+1:0] sum;
        sum = {2'b00, a} + {2'b00, b} + {2'b00, c} + {2'b00, d};
        return sum[PIX_W+1:2];
    endfunction

endpackage

### src/bbd_raw_if.sv
// Request channel carrying raw Bayer samples.
interface bbd_raw_if import bbd_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [PIX_W-1:0] raw_pixel;

    modport source (output valid, output raw_pixel, input ready);
    modport sink (input valid, input raw_pixel, output ready);
endinterface

### src/bbd_pix_if.sv
// Request channel carrying demosaiced BGR pixels.
interface bbd_pix_if import bbd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] pixel_row;
    logic [POS_W-1:0] pixel_col;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
    logic             quad_last;

    modport source (output valid, output pixel_row, output pixel_col, output blue,
                    output green, output red, output quad_last, input ready);
    modport sink (input valid, input pixel_row, input pixel_col, input blue,
                  input green, input red, input quad_last, output ready);
endinterface

### src/bbd_quad_out.sv
// Output buffer that holds one quad and hands out its four pixels in order.
module bbd_quad_out import bbd_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  quad_t     quad,
    input  logic      load,
    output logic      free,
    bbd_pix_if.source pix
);

    localparam logic [1:0] LAST_IDX = 2'd3;

    logic       busy_reg;
    logic       busy_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    quad_t      quad_reg;

    // The buffer can take a new quad once its last pixel leaves.
    assign free = !busy_reg || (idx_reg == LAST_IDX && pix.ready);

    // Pixel index and occupancy.
    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (load)
        begin
            busy_next = 1'b1;
            idx_next  = 2'd0;
        end
        else if (busy_reg && pix.ready)
        begin
            if (idx_reg == LAST_IDX)
            begin
                busy_next = 1'b0;
            end
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    // Quad payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            quad_reg <= quad;
        end
    end

    // Select the current pixel; base row and column are even.
    assign pix.valid     = busy_reg;
    assign pix.pixel_row = {quad_reg.row[POS_W-1:1], idx_reg[1]};
    assign pix.pixel_col = {quad_reg.col[POS_W-1:1], idx_reg[0]};
    assign pix.blue      = quad_reg.blue[idx_reg];
    assign pix.green     = quad_reg.green[idx_reg];
    assign pix.red       = quad_reg.red[idx_reg];
    assign pix.quad_last = (idx_reg == LAST_IDX);

endmodule

### src/bayer_bilinear_demosaic_unit.sv
// Bilinear GRBG Bayer demosaic: line store, 4x4 window and quad output buffer.
//
// Usage: raw Bayer samples enter on the raw channel in raster order, one per
// request. When the sample at row r+2, column c+2 arrives (r, c even, inside
// the emission bounds), four BGR pixels of the quad at (r, c) leave on the pix
// channel, in the order (r,c), (r,c+1), (r+1,c), (r+1,c+1); quad_last marks
// the fourth. Border pixels are never produced.
// Pipeline: the request that completes a quad is registered into the window
// stage with its line-store read; the window update and the buffer load follow
// once the buffer is free, and then the first pixel of the quad is valid.
// Throughput: a sample that completes no quad is taken every cycle unless the
// window stage holds an emitting sample. A quad leaves as four pixels through
// the single output port of the quad buffer, which sets the sustained rate on
// emitting rows, where every second sample completes a quad.
// Frame size is written through cfg_we / cfg_index / cfg_data while idle.
// Reset clears the counters, the window and the pipeline; the line store is
// not cleared and needs no clearing pass. When the receiver stalls, the quad
// buffer holds, the next emitting sample waits in the window stage, and the
// raw channel drops ready; nothing is lost.
module bayer_bilinear_demosaic_unit import bbd_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [0:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    bbd_raw_if.sink          raw,
    bbd_pix_if.source        pix
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam logic [CFG_W:0] MAXW  = (CFG_W+1)'(MAX_WIDTH);
    localparam logic [CFG_W:0] ONE   = (CFG_W+1)'(1);
    localparam logic [CFG_W:0] TWO   = (CFG_W+1)'(2);
    localparam logic [CFG_W:0] FOUR  = (CFG_W+1)'(4);
    localparam logic [POS_W-1:0] OFS = POS_W'(2);

    // Configuration registers.
    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= CFG_W'(640);
            frame_height_reg <= CFG_W'(480);
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          frame_width_reg  <= frame_width_reg;
            endcase
        end
    end

    // Effective frame size: width limited to 1..MAX_WIDTH, zero height as 1.
    logic [CFG_W:0] w_eff;
    logic [CFG_W:0] h_eff;
    logic [CFG_W:0] fw_ext;
    logic [CFG_W:0] fh_ext;

    always_comb
    begin
        fw_ext = {1'b0, frame_width_reg};
        fh_ext = {1'b0, frame_height_reg};
        if (fw_ext > MAXW)
            w_eff = MAXW;
        else if (fw_ext == '0)
            w_eff = ONE;
        else
            w_eff = fw_ext;
        h_eff = (fh_ext == '0) ? ONE : fh_ext;
    end

    // Position counters and handshake of the input stage.
    logic [CW-1:0]    col_reg;
    logic [CW-1:0]    col_next;
    logic [CFG_W-1:0] row_reg;
    logic [CFG_W-1:0] row_next;
    logic [CFG_W:0]   col_ext;
    logic [CFG_W:0]   row_ext;
    logic             emit_now;
    logic             accept;

    logic             s1_valid_reg;
    logic             s1_emit_reg;
    logic [CW-1:0]    s1_col_reg;
    logic [POS_W-1:0] s1_row_reg;
    pix_t             s1_px_reg;
    logic             s1_advance;
    logic             q_free;
    logic             q_load;

    assign raw.ready = !s1_valid_reg || s1_advance;
    assign accept    = raw.valid && raw.ready;

    always_comb
    begin
        col_ext  = (CFG_W+1)'(col_reg);
        row_ext  = {1'b0, row_reg};
        emit_now = !row_reg[0] && !col_reg[0] && (row_ext >= FOUR) && (col_ext >= FOUR)
                   && ((row_ext + TWO) < h_eff) && (col_ext < w_eff);
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if ((col_ext + ONE) >= w_eff)
            begin
                col_next = '0;
                row_next = ((row_ext + ONE) >= h_eff) ? '0 : row_reg + CFG_W'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Line store: three earlier samples per column, read on request,
    // written back when the window stage retires the sample.
    logic [LS_W-1:0]  line_mem [MAX_WIDTH];
    logic [LS_W-1:0]  rd_data_reg;
    logic [LS_W-1:0]  fwd_data_reg;
    logic             fwd_hit_reg;
    logic [LS_W-1:0]  ls_data;
    logic [COL_W-1:0] column;
    logic [LS_W-1:0]  wr_data;

    assign ls_data = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
    assign column  = {s1_px_reg, ls_data};
    assign wr_data = column[COL_W-1:PIX_W];

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            line_mem[s1_col_reg] <= wr_data;
        end
        if (accept)
        begin
            rd_data_reg  <= line_mem[col_reg];
            fwd_data_reg <= wr_data;
        end
    end

    // A read that meets a write to the same column takes the written data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else if (accept)
        begin
            fwd_hit_reg <= s1_advance && (s1_col_reg == col_reg);
        end
    end

    // Window stage control.
    assign q_load     = s1_valid_reg && s1_emit_reg && q_free;
    assign s1_advance = s1_valid_reg && (!s1_emit_reg || q_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_emit_reg <= emit_now;
            s1_col_reg  <= col_reg;
            s1_row_reg  <= POS_W'(row_reg);
            s1_px_reg   <= raw.raw_pixel;
        end
    end

    // 4x4 window of the last four columns.
    logic [COL_W-1:0] win_reg [4];
    logic [COL_W-1:0] nw [4];

    always_comb
    begin
        nw[0] = win_reg[1];
        nw[1] = win_reg[2];
        nw[2] = win_reg[3];
        nw[3] = column;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (s1_advance)
        begin
            for (int i = 0; i < 4; i++)
            begin
                win_reg[i] <= nw[i];
            end
        end
    end

    // Bilinear interpolation of the quad from the updated window.
    pix_t  b12, g13, b14, r21, g22, r23, g24, g31, b32, g33, b34, r41, g42, r43;
    quad_t quad;

    always_comb
    begin
        b12 = nw[1][0*PIX_W +: PIX_W];
        g13 = nw[2][0*PIX_W +: PIX_W];
        b14 = nw[3][0*PIX_W +: PIX_W];
        r21 = nw[0][1*PIX_W +: PIX_W];
        g22 = nw[1][1*PIX_W +: PIX_W];
        r23 = nw[2][1*PIX_W +: PIX_W];
        g24 = nw[3][1*PIX_W +: PIX_W];
        g31 = nw[0][2*PIX_W +: PIX_W];
        b32 = nw[1][2*PIX_W +: PIX_W];
        g33 = nw[2][2*PIX_W +: PIX_W];
        b34 = nw[3][2*PIX_W +: PIX_W];
        r41 = nw[0][3*PIX_W +: PIX_W];
        g42 = nw[1][3*PIX_W +: PIX_W];
        r43 = nw[2][3*PIX_W +: PIX_W];

        quad.row      = s1_row_reg - OFS;
        quad.col      = POS_W'(s1_col_reg) - OFS;
        quad.blue[0]  = avg2(b12, b32);
        quad.green[0] = g22;
        quad.red[0]   = avg2(r21, r23);
        quad.blue[1]  = avg4(b12, b14, b32, b34);
        quad.green[1] = avg4(g13, g33, g22, g24);
        quad.red[1]   = r23;
        quad.blue[2]  = b32;
        quad.green[2] = avg4(g22, g42, g31, g33);
        quad.red[2]   = avg4(r21, r23, r41, r43);
        quad.blue[3]  = avg2(b32, b34);
        quad.green[3] = g33;
        quad.red[3]   = avg2(r23, r43);
    end

    bbd_quad_out u_quad_out (
        .clk   (clk),
        .rst_n (rst_n),
        .quad  (quad),
        .load  (q_load),
        .free  (q_free),
        .pix   (pix)
    );

    // The window stage only holds a quad-producing sample behind a busy output.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_advance) |-> (s1_emit_reg && pix.valid))
        else $error("window stage stalled without a pending quad");

    // A held sample must block new requests so its line-store read stays valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_advance) |=> ($stable(rd_data_reg) && s1_valid_reg))
        else $error("held sample lost its line-store data");

    // The column counter never leaves the line store.
    assert property (@(posedge clk) disable iff (!rst_n)
        (CFG_W+1)'(col_reg) < MAXW)
        else $error("column counter beyond line store depth");

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the GRBG bilinear demosaic unit with random stimulus and stalls.
module testbench;
    import bbd_pkg::*;

    localparam int LINE_DEPTH     = 4096;
    localparam int IDLE_MAX       = 11;
    localparam int HOLDOFF_AT     = 5;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int STALL_LIMIT    = 4000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int ERR_PRINT_MAX  = 40;
    localparam int RANDOM_ITEMS   = 100;

    // One expected colour pixel as it should leave the pix channel.
    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
        logic             last;
    } bgr_pix_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [0:0]       cfg_index;
    logic [CFG_W-1:0] cfg_data;

    bbd_raw_if raw_ch ();
    bbd_pix_if pix_ch ();

    bayer_bilinear_demosaic_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .raw       (raw_ch),
        .pix       (pix_ch)
    );

    // Free-running clock, 20 ns period.
    always #10 clk = ~clk;

    // Shadow copy of the block: frame size, line store, window and position.
    logic [CFG_W-1:0] frame_w;
    logic [CFG_W-1:0] frame_h;
    logic [LS_W-1:0]  col_hist [LINE_DEPTH];
    logic [COL_W-1:0] win_cols [4];
    int unsigned      next_col;
    int unsigned      next_row;

    pix_t     pixel_q [$];
    bgr_pix_t pending_bgr [$];
    int       fail_count = 0;

    // Driver and monitor bookkeeping.
    int   send_wait;
    int   send_next;
    logic send_burst;
    int   rcv_wait;
    int   rcv_next;
    logic rcv_burst;
    int   results_seen;
    logic holdoff_done;
    int   quiet_cycles;
    bgr_pix_t got_exp;

    // Sample at window row rw (0 oldest) and window column cl (0 oldest).
    function automatic pix_t tap(int rw, int cl);
        return win_cols[cl][8*rw +: 8];
    endfunction

    function automatic void push_bgr(int unsigned r, int unsigned c, int b, int g, int rd,
                                     logic last);
        bgr_pix_t p;
        p.row   = POS_W'(r);
        p.col   = POS_W'(c);
        p.blue  = PIX_W'(b);
        p.green = PIX_W'(g);
        p.red   = PIX_W'(rd);
        p.last  = last;
        pending_bgr.push_back(p);
    endfunction

    // Advance the shadow state by one raw sample and queue the quad it completes, if any.
    function automatic void demosaic_sample(pix_t px);
        int unsigned      w;
        int unsigned      h;
        int unsigned      idx;
        int unsigned      r;
        int unsigned      c;
        logic [COL_W-1:0] column;
        int b12, g13, b14, r21, g22, r23, g24, g31, b32, g33, b34, r41, g42, r43;
        w = frame_w;
        if (w > LINE_DEPTH)
            w = LINE_DEPTH;
        if (w == 0)
            w = 1;
        h = (frame_h == 0) ? 1 : frame_h;
        idx = (next_col < LINE_DEPTH) ? next_col : LINE_DEPTH - 1;

        // The new sample goes on top of the three older rows of its column.
        column = {px, col_hist[idx]};
        col_hist[idx] = column[COL_W-1:PIX_W];
        win_cols[0] = win_cols[1];
        win_cols[1] = win_cols[2];
        win_cols[2] = win_cols[3];
        win_cols[3] = column;

        if ((next_row % 2) == 0 && (next_col % 2) == 0 && next_row >= 4 && next_col >= 4 &&
            next_row + 2 < h && next_col < w)
        begin
            r   = next_row - 2;
            c   = next_col - 2;
            b12 = tap(0, 1);
            g13 = tap(0, 2);
            b14 = tap(0, 3);
            r21 = tap(1, 0);
            g22 = tap(1, 1);
            r23 = tap(1, 2);
            g24 = tap(1, 3);
            g31 = tap(2, 0);
            b32 = tap(2, 1);
            g33 = tap(2, 2);
            b34 = tap(2, 3);
            r41 = tap(3, 0);
            g42 = tap(3, 1);
            r43 = tap(3, 2);
            push_bgr(r, c, (b12 + b32) / 2, g22, (r21 + r23) / 2, 1'b0);
            push_bgr(r, c + 1, (b12 + b14 + b32 + b34) / 4, (g13 + g33 + g22 + g24) / 4,
                     r23, 1'b0);
            push_bgr(r + 1, c, b32, (g22 + g42 + g31 + g33) / 4,
                     (r21 + r23 + r41 + r43) / 4, 1'b0);
            push_bgr(r + 1, c + 1, (b32 + b34) / 2, g33, (r23 + r43) / 2, 1'b1);
        end

        // Raster position of the next sample; a shrunken frame wraps on the next sample.
        if (next_col + 1 >= w)
        begin
            next_col = 0;
            next_row = (next_row + 1 >= h) ? 0 : next_row + 1;
        end
        else
        begin
            next_col = next_col + 1;
        end
    endfunction

    function automatic void check_field(string name, int unsigned expv, int unsigned actv);
        if (expv != actv)
        begin
            fail_count++;
            if (fail_count <= ERR_PRINT_MAX)
                $error("%s: expected %0d, actual %0d", name, expv, actv);
        end
    endfunction

    task automatic write_frame_reg(cfg_reg_t which, logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (which == REG_FRAME_WIDTH)
            frame_w = value;
        else
            frame_h = value;
    endtask

    task automatic set_frame(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
        write_frame_reg(REG_FRAME_WIDTH, w);
        write_frame_reg(REG_FRAME_HEIGHT, h);
    endtask

    // Random samples with the extreme values drawn more often.
    task automatic queue_pixels(int n);
        @(negedge clk);
        repeat (n)
        begin
            case ($urandom_range(0, 7))
                0: pixel_q.push_back(8'h00);
                1: pixel_q.push_back(8'hFF);
                default: pixel_q.push_back(PIX_W'($urandom_range(0, 255)));
            endcase
        end
    endtask

    // Wait until every queued sample is taken and every expected pixel has come.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pixel_q.size() != 0 || raw_ch.valid || pending_bgr.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Sample driver: one request per queued sample, with a random gap after each outside bursts.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            raw_ch.valid     <= 1'b0;
            raw_ch.raw_pixel <= '0;
            send_wait        <= 0;
            send_burst       <= 1'b0;
        end
        else
        begin
            send_next = send_wait;
            if (raw_ch.valid && raw_ch.ready)
            begin
                demosaic_sample(raw_ch.raw_pixel);
                send_next = send_burst ? 0 : $urandom_range(0, IDLE_MAX);
                if ($urandom_range(0, 39) == 0)
                    send_burst <= !send_burst;
            end
            if (!(raw_ch.valid && !raw_ch.ready))
            begin
                if (send_next != 0)
                begin
                    raw_ch.valid <= 1'b0;
                    send_wait    <= send_next - 1;
                end
                else if (pixel_q.size() != 0)
                begin
                    raw_ch.valid     <= 1'b1;
                    raw_ch.raw_pixel <= pixel_q.pop_front();
                end
                else
                begin
                    raw_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Pixel monitor: checks each accepted request and stalls ready at random.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pix_ch.ready <= 1'b0;
            rcv_wait     <= 0;
            rcv_burst    <= 1'b0;
            results_seen <= 0;
            holdoff_done <= 1'b0;
        end
        else
        begin
            rcv_next = rcv_wait;
            if (pix_ch.valid && pix_ch.ready)
            begin
                if (pending_bgr.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= ERR_PRINT_MAX)
                        $error("unexpected pixel at row %0d, col %0d",
                               pix_ch.pixel_row, pix_ch.pixel_col);
                end
                else
                begin
                    got_exp = pending_bgr.pop_front();
                    check_field("pixel_row", got_exp.row, pix_ch.pixel_row);
                    check_field("pixel_col", got_exp.col, pix_ch.pixel_col);
                    check_field("blue", got_exp.blue, pix_ch.blue);
                    check_field("green", got_exp.green, pix_ch.green);
                    check_field("red", got_exp.red, pix_ch.red);
                    check_field("quad_last", got_exp.last, pix_ch.quad_last);
                end
                results_seen <= results_seen + 1;
                // One long hold-off so the block fills up and stalls its input.
                if (!holdoff_done && results_seen >= HOLDOFF_AT)
                begin
                    rcv_next = HOLDOFF_CYCLES;
                    holdoff_done <= 1'b1;
                end
                else
                begin
                    rcv_next = rcv_burst ? 0 : $urandom_range(0, IDLE_MAX);
                end
                if ($urandom_range(0, 39) == 0)
                    rcv_burst <= !rcv_burst;
            end
            if (rcv_next != 0)
            begin
                pix_ch.ready <= 1'b0;
                rcv_wait     <= rcv_next - 1;
            end
            else
            begin
                pix_ch.ready <= 1'b1;
                rcv_wait     <= 0;
            end
        end
    end

    // Watchdog: too long without any accepted request on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (raw_ch.valid && raw_ch.ready) || (pix_ch.valid && pix_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus sequence.
    initial
    begin
        int fw;
        int fh;
        int split;
        int rand_items;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = REG_FRAME_WIDTH;
        cfg_data         = '0;
        raw_ch.valid     = 1'b0;
        raw_ch.raw_pixel = '0;
        pix_ch.ready     = 1'b0;
        frame_w          = 13'd640;
        frame_h          = 13'd480;
        next_col         = 0;
        next_row         = 0;
        foreach (col_hist[i])
            col_hist[i] = '0;
        foreach (win_cols[i])
            win_cols[i] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // A small frame with a fixed pattern of 0, 1, 254 and 255 around its one quad.
        set_frame(13'd6, 13'd8);
        @(negedge clk);
        for (int r = 0; r < 8; r++)
        begin
            for (int c = 0; c < 6; c++)
            begin
                if ((r + c) % 2 == 1)
                    pixel_q.push_back((r == 3) ? 8'h01 : 8'hFF);
                else
                    pixel_q.push_back((r % 4 < 2) ? 8'h00 : 8'hFE);
            end
        end
        wait_drained();

        // Size changes in the middle of a frame, counters past the new bounds.
        // The long receiver hold-off falls on the first quad of this frame.
        set_frame(13'd12, 13'd10);
        queue_pixels(5 * 12 + 9);
        wait_drained();
        write_frame_reg(REG_FRAME_WIDTH, 13'd6);
        queue_pixels(19);
        wait_drained();
        write_frame_reg(REG_FRAME_HEIGHT, 13'd6);
        queue_pixels(14);
        wait_drained();
        write_frame_reg(REG_FRAME_WIDTH, 13'd12);
        queue_pixels(24);
        wait_drained();

        // Out-of-range sizes: a very tall frame, then zero width and zero height.
        set_frame(13'd6, 13'h1FFF);
        queue_pixels(30);
        wait_drained();
        write_frame_reg(REG_FRAME_HEIGHT, 13'd10);
        queue_pixels(16);
        wait_drained();
        write_frame_reg(REG_FRAME_WIDTH, 13'd0);
        queue_pixels(4);
        wait_drained();
        write_frame_reg(REG_FRAME_HEIGHT, 13'd0);
        queue_pixels(4);
        wait_drained();

        // Width past the line store from the origin, then back to the origin.
        write_frame_reg(REG_FRAME_WIDTH, 13'h1FFF);
        queue_pixels(10);
        wait_drained();
        write_frame_reg(REG_FRAME_WIDTH, 13'd0);
        queue_pixels(1);
        wait_drained();

        // Whole small frames of random size; some are split by a full drain.
        rand_items = 0;
        while (rand_items < RANDOM_ITEMS)
        begin
            fw = 2 * $urandom_range(3, 5) + ($urandom_range(0, 3) == 0);
            fh = 2 * $urandom_range(4, 5) + ($urandom_range(0, 3) == 0);
            set_frame(CFG_W'(fw), CFG_W'(fh));
            split = ($urandom_range(0, 1) == 1) ? $urandom_range(1, fw * fh - 1) : fw * fh;
            queue_pixels(split);
            if (split < fw * fh)
            begin
                wait_drained();
                queue_pixels(fw * fh - split);
            end
            wait_drained();
            rand_items += fw * fh;
        end

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
